FILE: design/ijs_pkg.sv
// Shared widths, sequencer states and step counts for the interval jitter statistics unit.
`default_nettype none

package ijs_pkg;

   localparam int TS_W    = 64;          // timestamp width
   localparam int CNT_W   = 8;           // delta count width
   localparam int FIELD_W = 24;          // width of each statistic on the result channel
   localparam int DIV_W   = 2 * CNT_W;   // widest divisor (count squared)
   localparam int STEP_W  = 6;           // iteration counter width

   // Last iteration index of each multi-cycle phase.
   localparam logic [STEP_W-1:0] VAR_LAST  = 6'd63;   // 64-bit dividend, one bit a cycle
   localparam logic [STEP_W-1:0] ROOT_LAST = 6'd31;   // 64-bit radicand, two bits a cycle
   localparam logic [STEP_W-1:0] MEAN_LAST = 6'd31;   // 32-bit dividend, one bit a cycle

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_SQUARE   = 12'b0000_0000_0010,
      ST_ACCUM    = 12'b0000_0000_0100,
      ST_MUL_NN   = 12'b0000_0000_1000,
      ST_MUL_SS   = 12'b0000_0001_0000,
      ST_MUL_NL   = 12'b0000_0010_0000,
      ST_MUL_NH   = 12'b0000_0100_0000,
      ST_SUB      = 12'b0000_1000_0000,
      ST_DIV_VAR  = 12'b0001_0000_0000,
      ST_SQRT     = 12'b0010_0000_0000,
      ST_DIV_MEAN = 12'b0100_0000_0000,
      ST_RESULT   = 12'b1000_0000_0000
   } state_type;

endpackage

`default_nettype wire

FILE: design/ijs_channels.sv
// Valid/ready channel interfaces for timestamp transactions and statistics results.
`default_nettype none

interface ijs_req_intf;
   logic                      valid;
   logic                      ready;
   logic [ijs_pkg::TS_W-1:0]  timestamp;
   logic                      last_sample;

   modport source (output valid, output timestamp, output last_sample, input ready);
   modport sink   (input valid, input timestamp, input last_sample, output ready);
endinterface

interface ijs_rsp_intf;
   logic                         valid;
   logic                         ready;
   logic [ijs_pkg::CNT_W-1:0]    delta_count;
   logic [ijs_pkg::FIELD_W-1:0]  min_delta;
   logic [ijs_pkg::FIELD_W-1:0]  max_delta;
   logic [ijs_pkg::FIELD_W-1:0]  mean_delta;
   logic [ijs_pkg::FIELD_W-1:0]  midrange_delta;
   logic [ijs_pkg::FIELD_W-1:0]  std_dev;
   logic                         saturated;
   logic                         empty_run;

   modport source (output valid, output delta_count, output min_delta, output max_delta,
                   output mean_delta, output midrange_delta, output std_dev,
                   output saturated, output empty_run, input ready);
   modport sink   (input valid, input delta_count, input min_delta, input max_delta,
                   input mean_delta, input midrange_delta, input std_dev,
                   input saturated, input empty_run, output ready);
endinterface

`default_nettype wire

FILE: design/interval_jitter_stats_unit.sv
// Interval jitter statistics: timestamp deltas to count, min, max, mean, midrange, stdev.
//
// Usage: timestamps of one run enter on req_ch, one per transaction; last_sample marks
// the final one. Each timestamp after the first forms a delta to its predecessor
// (modulo 2^64), clipped to DELTA_BITS bits; deltas past MAX_SAMPLES-1 are dropped.
// Both events raise the saturated flag of the run's result.
// Sequence: a timestamp that is not last is subtracted and clipped, squared through the
// shared multiplier and accumulated; req_ch.ready is low meanwhile. A last timestamp of
// a run with deltas then takes the multiplies n*n, S*S and the two halves of n*S2, the
// subtract, the variance divide, the square root and the mean divide before its result
// is registered; a run with no deltas goes from accumulate straight to the result. The
// single multiplier and the single 64-bit subtractor set this sequence; the divider and
// square-root iterations reuse the subtractor one bit (or bit pair) a cycle.
// Results leave on rsp_ch from an output register. While the receiver stalls, the
// next run's timestamps are still taken; only a second result waits for the first.
// Reset (synchronous, active high) clears the run and drops any pending result.
`default_nettype none

module interval_jitter_stats_unit #(
   parameter int MAX_SAMPLES = 256,
   parameter int DELTA_BITS  = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ijs_req_intf.sink        req_ch,
   ijs_rsp_intf.source      rsp_ch
);

   localparam int SUM_W = DELTA_BITS + ijs_pkg::CNT_W;
   localparam int SQ_W  = 2 * DELTA_BITS + ijs_pkg::CNT_W;
   localparam logic [ijs_pkg::CNT_W-1:0] CAP = ijs_pkg::CNT_W'(MAX_SAMPLES - 1);
   localparam logic [DELTA_BITS-1:0] LIMIT = {DELTA_BITS{1'b1}};

   ijs_pkg::state_type state_ff, state_in;

   // Run state.
   logic [ijs_pkg::TS_W-1:0]   prev_ff, prev_in;
   logic                       have_prev_ff, have_prev_in;
   logic [ijs_pkg::CNT_W-1:0]  tally_ff, tally_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [SQ_W-1:0]            sqsum_ff, sqsum_in;
   logic [DELTA_BITS-1:0]      min_ff, min_in;
   logic [DELTA_BITS-1:0]      max_ff, max_in;
   logic                       clip_ff, clip_in;

   // Per-transaction and sequencer working registers.
   logic                       last_ff, last_in;
   logic                       take_ff, take_in;
   logic [DELTA_BITS-1:0]      delta_ff, delta_in;
   logic [ijs_pkg::DIV_W-1:0]  nn_ff, nn_in;
   logic [63:0]                ss_ff, ss_in;
   logic [63:0]                acc_ff, acc_in;
   logic [63:0]                work_ff, work_in;
   logic [ijs_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [63:0]                root_ff, root_in;
   logic [63:0]                probe_ff, probe_in;
   logic [ijs_pkg::STEP_W-1:0] step_ff, step_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ijs_pkg::CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [ijs_pkg::FIELD_W-1:0]  rsp_min_ff, rsp_min_in;
   logic [ijs_pkg::FIELD_W-1:0]  rsp_max_ff, rsp_max_in;
   logic [ijs_pkg::FIELD_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [ijs_pkg::FIELD_W-1:0]  rsp_mid_ff, rsp_mid_in;
   logic [ijs_pkg::FIELD_W-1:0]  rsp_std_ff, rsp_std_in;
   logic                         rsp_sat_ff, rsp_sat_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   // Shared units.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] sub_a, sub_b;
   logic [64:0] sub_d;
   logic        sub_ge;

   logic                       req_acc;
   logic                       over;
   logic                       below_cap;
   logic [ijs_pkg::DIV_W-1:0]  divisor;
   logic [63:0]                sq64;
   logic [DELTA_BITS-1:0]      mid_val;

   assign req_ch.ready = (state_ff == ijs_pkg::ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign sq64    = 64'(sqsum_ff);
   assign divisor = (state_ff == ijs_pkg::ST_DIV_VAR) ? nn_ff
                                                      : ijs_pkg::DIV_W'(tally_ff);

   // Shared multiplier operand selection.
   always_comb begin
      case (state_ff)
         ijs_pkg::ST_SQUARE: begin
            mul_a = 32'(delta_ff);
            mul_b = 32'(delta_ff);
         end
         ijs_pkg::ST_MUL_NN: begin
            mul_a = 32'(tally_ff);
            mul_b = 32'(tally_ff);
         end
         ijs_pkg::ST_MUL_SS: begin
            mul_a = 32'(sum_ff);
            mul_b = 32'(sum_ff);
         end
         ijs_pkg::ST_MUL_NL: begin
            mul_a = 32'(tally_ff);
            mul_b = sq64[31:0];
         end
         ijs_pkg::ST_MUL_NH: begin
            mul_a = 32'(tally_ff);
            mul_b = sq64[63:32];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Shared subtractor: timestamp delta, n*S2 - S*S, divide trials and root trials.
   always_comb begin
      case (state_ff)
         ijs_pkg::ST_DIV_VAR, ijs_pkg::ST_DIV_MEAN: begin
            sub_a = 64'({rem_ff, work_ff[63]});
            sub_b = 64'(divisor);
         end
         ijs_pkg::ST_SQRT: begin
            sub_a = work_ff;
            // The trial bit always lies below the lowest set bit of the partial root.
            sub_b = root_ff | probe_ff;
         end
         ijs_pkg::ST_SUB: begin
            sub_a = acc_ff;
            sub_b = ss_ff;
         end
         default: begin
            sub_a = req_ch.timestamp;
            sub_b = prev_ff;
         end
      endcase
   end

   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = !sub_d[64];

   assign over      = (sub_d[63:0] >> DELTA_BITS) != 64'd0;
   assign below_cap = tally_ff < CAP;
   assign mid_val   = min_ff + ((max_ff - min_ff) >> 1);

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      tally_in     = tally_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      clip_in      = clip_ff;
      last_in      = last_ff;
      take_in      = take_ff;
      delta_in     = delta_ff;
      nn_in        = nn_ff;
      ss_in        = ss_ff;
      acc_in       = acc_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      probe_in     = probe_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in = rsp_count_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_mid_in   = rsp_mid_ff;
      rsp_std_in   = rsp_std_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_empty_in = rsp_empty_ff;

      case (state_ff)
         ijs_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (have_prev_ff) begin
                  clip_in = clip_ff || over || !below_cap;
               end
               take_in      = have_prev_ff && below_cap;
               delta_in     = over ? LIMIT : sub_d[DELTA_BITS-1:0];
               prev_in      = req_ch.timestamp;
               have_prev_in = 1'b1;
               last_in      = req_ch.last_sample;
               state_in     = ijs_pkg::ST_SQUARE;
            end
         end
         ijs_pkg::ST_SQUARE: begin
            ss_in    = mul_p;
            state_in = ijs_pkg::ST_ACCUM;
         end
         ijs_pkg::ST_ACCUM: begin
            if (take_ff) begin
               sum_in   = sum_ff + SUM_W'(delta_ff);
               sqsum_in = sqsum_ff + ss_ff[SQ_W-1:0];
               if (tally_ff == '0 || delta_ff < min_ff) begin
                  min_in = delta_ff;
               end
               if (delta_ff > max_ff) begin
                  max_in = delta_ff;
               end
               tally_in = tally_ff + 1'b1;
            end
            if (!last_ff) begin
               state_in = ijs_pkg::ST_IDLE;
            end else if (tally_in == '0) begin
               state_in = ijs_pkg::ST_RESULT;
            end else begin
               state_in = ijs_pkg::ST_MUL_NN;
            end
         end
         ijs_pkg::ST_MUL_NN: begin
            nn_in    = mul_p[ijs_pkg::DIV_W-1:0];
            state_in = ijs_pkg::ST_MUL_SS;
         end
         ijs_pkg::ST_MUL_SS: begin
            ss_in    = mul_p;
            state_in = ijs_pkg::ST_MUL_NL;
         end
         ijs_pkg::ST_MUL_NL: begin
            acc_in   = mul_p;
            state_in = ijs_pkg::ST_MUL_NH;
         end
         ijs_pkg::ST_MUL_NH: begin
            acc_in   = acc_ff + {mul_p[31:0], 32'd0};
            state_in = ijs_pkg::ST_SUB;
         end
         ijs_pkg::ST_SUB: begin
            work_in  = sub_d[63:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = ijs_pkg::ST_DIV_VAR;
         end
         ijs_pkg::ST_DIV_VAR, ijs_pkg::ST_DIV_MEAN: begin
            if (sub_ge) begin
               rem_in  = sub_d[ijs_pkg::DIV_W-1:0];
               work_in = {work_ff[62:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[ijs_pkg::DIV_W-2:0], work_ff[63]};
               work_in = {work_ff[62:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (state_ff == ijs_pkg::ST_DIV_VAR && step_ff == ijs_pkg::VAR_LAST) begin
               // The variance quotient now in work_ff becomes the radicand.
               root_in  = '0;
               probe_in = 64'd1 << 62;
               step_in  = '0;
               state_in = ijs_pkg::ST_SQRT;
            end else if (state_ff == ijs_pkg::ST_DIV_MEAN &&
                         step_ff == ijs_pkg::MEAN_LAST) begin
               state_in = ijs_pkg::ST_RESULT;
            end
         end
         ijs_pkg::ST_SQRT: begin
            if (sub_ge) begin
               work_in = sub_d[63:0];
               root_in = (root_ff >> 1) | probe_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            probe_in = probe_ff >> 2;
            step_in  = step_ff + 1'b1;
            if (step_ff == ijs_pkg::ROOT_LAST) begin
               // Sum sits in the upper half so 32 steps leave the quotient in the lower.
               work_in  = {32'(sum_ff), 32'd0};
               rem_in   = '0;
               step_in  = '0;
               state_in = ijs_pkg::ST_DIV_MEAN;
            end
         end
         ijs_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = tally_ff;
               rsp_sat_in   = clip_ff;
               if (tally_ff == '0) begin
                  rsp_empty_in = 1'b1;
                  rsp_min_in   = '0;
                  rsp_max_in   = '0;
                  rsp_mean_in  = '0;
                  rsp_mid_in   = '0;
                  rsp_std_in   = '0;
               end else begin
                  rsp_empty_in = 1'b0;
                  rsp_min_in   = ijs_pkg::FIELD_W'(min_ff);
                  rsp_max_in   = ijs_pkg::FIELD_W'(max_ff);
                  rsp_mean_in  = work_ff[ijs_pkg::FIELD_W-1:0];
                  rsp_mid_in   = ijs_pkg::FIELD_W'(mid_val);
                  rsp_std_in   = root_ff[ijs_pkg::FIELD_W-1:0];
               end
               prev_in      = '0;
               have_prev_in = 1'b0;
               tally_in     = '0;
               sum_in       = '0;
               sqsum_in     = '0;
               min_in       = LIMIT;
               max_in       = '0;
               clip_in      = 1'b0;
               state_in     = ijs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ijs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ijs_pkg::ST_IDLE;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         tally_ff     <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         min_ff       <= LIMIT;
         max_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         tally_ff     <= tally_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      take_ff      <= take_in;
      delta_ff     <= delta_in;
      nn_ff        <= nn_in;
      ss_ff        <= ss_in;
      acc_ff       <= acc_in;
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      probe_ff     <= probe_in;
      step_ff      <= step_in;
      rsp_count_ff <= rsp_count_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_mid_ff   <= rsp_mid_in;
      rsp_std_ff   <= rsp_std_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.delta_count    = rsp_count_ff;
   assign rsp_ch.min_delta      = rsp_min_ff;
   assign rsp_ch.max_delta      = rsp_max_ff;
   assign rsp_ch.mean_delta     = rsp_mean_ff;
   assign rsp_ch.midrange_delta = rsp_mid_ff;
   assign rsp_ch.std_dev        = rsp_std_ff;
   assign rsp_ch.saturated      = rsp_sat_ff;
   assign rsp_ch.empty_run      = rsp_empty_ff;

   // A newly loaded result always leaves a cleared run behind it.
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (tally_ff == '0 && !have_prev_ff && !clip_ff))
      else $error("run state not cleared after result");

   // A delta arriving at the sample cap must raise the saturation flag.
   a_cap_sets_clip: assert property (@(posedge clock) disable iff (reset)
      (req_acc && have_prev_ff && !below_cap) |=> clip_ff)
      else $error("dropped delta did not set saturation");

   // An empty run reports zero statistics.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |->
         (rsp_count_ff == '0 && rsp_min_ff == '0 && rsp_max_ff == '0 && rsp_std_ff == '0))
      else $error("empty run with nonzero statistics");

   // Midrange lies between minimum and maximum.
   a_mid_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_empty_ff) |->
         (rsp_min_ff <= rsp_mid_ff && rsp_mid_ff <= rsp_max_ff))
      else $error("midrange outside min/max");

endmodule

`default_nettype wire
